/* hdl/jmsp_pkg.sv */
// ----------------------------------------------------------------------------
// jmsp_pkg
// Shared types and constants for the JPEG marker segment parser.
// ----------------------------------------------------------------------------
package jmsp_pkg;

    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_00   = 8'h00;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_DHT    = 8'hC4;
    localparam logic [7:0] MK_DQT    = 8'hDB;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_DRI    = 8'hDD;
    localparam logic [7:0] MK_EOI    = 8'hD9;
    localparam logic [7:0] MK_RST_LO = 8'hD0;
    localparam logic [7:0] MK_RST_HI = 8'hD7;

    localparam logic [15:0] DQT_DEC_NARROW = 16'd65;
    localparam logic [15:0] DQT_DEC_WIDE   = 16'd129;
    localparam logic [11:0] DQT_ENTRIES    = 12'd64;
    localparam logic [11:0] DHT_COUNTS     = 12'd16;

    typedef enum logic [3:0] {
        EV_HEIGHT     = 4'd0,
        EV_WIDTH      = 4'd1,
        EV_COMP_COUNT = 4'd2,
        EV_COMP_INFO  = 4'd3,
        EV_QUANT      = 4'd4,
        EV_HUFF_HDR   = 4'd5,
        EV_CODE_COUNT = 4'd6,
        EV_SYMBOL     = 4'd7,
        EV_DATA       = 4'd8,
        EV_FINISHED   = 4'd9,
        EV_ERROR      = 4'd10
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [3:0]  table_id;
        logic [3:0]  table_class;
        logic [11:0] item_index;
        logic [15:0] value;
        logic [3:0]  h_factor;
        logic [3:0]  v_factor;
        logic        stream_end;
    } result_t;

endpackage

/* hdl/jpeg_marker_segment_parser_unit.sv */
// A result is registered twice: its byte is held in the input register, then the result goes into the buffer.
// Throughput: one byte per cycle while the receiver keeps up; each byte
// updates the state once out of the input register into a two-entry buffer.
// Bytes that produce no result leave the buffer untouched.
// Reset (rst_n low, asynchronous) returns the parser to the start-of-image
// check and empties both input register and result buffer.
// ----------------------------------------------------------------------------
// jpeg_marker_segment_parser_unit
// Byte-serial JPEG marker and segment parser, at most one event per transaction.
// ----------------------------------------------------------------------------
module jpeg_marker_segment_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic [3:0]  table_id,
    output logic [3:0]  table_class,
    output logic [11:0] item_index,
    output logic [15:0] value,
    output logic [3:0]  h_factor,
    output logic [3:0]  v_factor,
    output logic        stream_end
);

    logic              res_room;
    logic              res_push;
    jmsp_pkg::result_t res_data;
    jmsp_pkg::result_t out_data;

    jmsp_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_value (byte_value),
        .res_room   (res_room),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    jmsp_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .room      (res_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign event_res   = out_data.event_res;
    assign table_id    = out_data.table_id;
    assign table_class = out_data.table_class;
    assign item_index  = out_data.item_index;
    assign value       = out_data.value;
    assign h_factor    = out_data.h_factor;
    assign v_factor    = out_data.v_factor;
    assign stream_end  = out_data.stream_end;

endmodule

/* hdl/jmsp_out_fifo.sv */
// ----------------------------------------------------------------------------
// jmsp_out_fifo
// Two-entry result buffer that decouples the parser from the output stall.
// ----------------------------------------------------------------------------
module jmsp_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  jmsp_pkg::result_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_stall,
    output jmsp_pkg::result_t out_data
);

    jmsp_pkg::result_t slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              pop;

    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/jmsp_core.sv */
// ----------------------------------------------------------------------------
// jmsp_core
// Input byte register and the marker/segment state machine.
// ----------------------------------------------------------------------------
module jmsp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        byte_value,
    input  logic              res_room,
    output logic              res_push,
    output jmsp_pkg::result_t res_data
);

    typedef enum logic [4:0] {
        P_SOI1, P_SOI2, P_FF, P_CODE, P_LEN_HI, P_LEN_LO,
        P_SOF_PREC, P_SOF_H_HI, P_SOF_H_LO, P_SOF_W_HI, P_SOF_W_LO, P_SOF_NC,
        P_SOF_CID, P_SOF_SAMP, P_SOF_TQ,
        P_DQT_PT, P_DQT_E_HI, P_DQT_E_LO,
        P_DHT_TC, P_DHT_CNT, P_DHT_SYM,
        P_SOS_SKIP, P_SOS_DATA, P_SOS_FF, P_SKIP, P_DONE
    } phase_t;

    logic        in_full_reg;
    logic [7:0]  byte_reg;
    logic        advance;

    phase_t      phase_reg,         phase_next;
    logic [7:0]  marker_code_reg,   marker_code_next;
    logic [15:0] seg_rem_reg,       seg_rem_next;
    logic [11:0] field_cnt_reg,     field_cnt_next;
    logic [7:0]  held_hi_reg,       held_hi_next;
    logic        wide_reg,          wide_next;
    logic [3:0]  cur_table_reg,     cur_table_next;
    logic [7:0]  comp_total_reg,    comp_total_next;
    logic [15:0] comp_hold_reg,     comp_hold_next;
    logic [11:0] sym_total_reg,     sym_total_next;

    logic [11:0] cnt_inc;
    logic [15:0] word;
    logic [15:0] len_m2;
    logic [15:0] rem_dec;
    logic [15:0] dqt_dec;
    logic        emit;
    jmsp_pkg::result_t res;

    assign in_stall = in_full_reg && !res_room;
    assign advance  = in_full_reg && res_room;
    assign res_push = advance && emit;
    assign res_data = res;

    assign cnt_inc = field_cnt_reg + 12'd1;
    assign word    = {held_hi_reg, byte_reg};
    assign len_m2  = word - 16'd2;
    assign rem_dec = seg_rem_reg - 16'd1;
    assign dqt_dec = wide_reg ? jmsp_pkg::DQT_DEC_WIDE : jmsp_pkg::DQT_DEC_NARROW;

    always_comb
    begin
        phase_next       = phase_reg;
        marker_code_next = marker_code_reg;
        seg_rem_next     = seg_rem_reg;
        field_cnt_next   = field_cnt_reg;
        held_hi_next     = held_hi_reg;
        wide_next        = wide_reg;
        cur_table_next   = cur_table_reg;
        comp_total_next  = comp_total_reg;
        comp_hold_next   = comp_hold_reg;
        sym_total_next   = sym_total_reg;
        emit             = 1'b0;
        res              = '0;

        unique case (phase_reg)
            P_SOI1, P_SOI2, P_FF:
            begin
                if ((phase_reg == P_SOI2) ? (byte_reg != jmsp_pkg::MK_SOI)
                                          : (byte_reg != jmsp_pkg::BYTE_FF))
                begin
                    phase_next     = P_DONE;
                    emit           = 1'b1;
                    res.event_res  = jmsp_pkg::EV_ERROR;
                    res.stream_end = 1'b1;
                end
                else
                begin
                    phase_next = (phase_reg == P_SOI1) ? P_SOI2 :
                                 (phase_reg == P_SOI2) ? P_FF : P_CODE;
                end
            end
            P_CODE:
            begin
                marker_code_next = byte_reg;
                phase_next       = P_LEN_HI;
            end
            P_LEN_HI, P_SOF_H_HI, P_SOF_W_HI:
            begin
                held_hi_next = byte_reg;
                phase_next   = (phase_reg == P_LEN_HI)   ? P_LEN_LO :
                               (phase_reg == P_SOF_H_HI) ? P_SOF_H_LO : P_SOF_W_LO;
            end
            P_LEN_LO:
            begin
                seg_rem_next = len_m2;
                priority if (marker_code_reg == jmsp_pkg::MK_DRI)
                begin
                    phase_next     = P_DONE;
                    emit           = 1'b1;
                    res.event_res  = jmsp_pkg::EV_FINISHED;
                    res.stream_end = 1'b1;
                end
                else if (marker_code_reg == jmsp_pkg::MK_SOF0)
                begin
                    phase_next = P_SOF_PREC;
                end
                else if (marker_code_reg == jmsp_pkg::MK_DQT)
                begin
                    phase_next = (len_m2 != 16'd0) ? P_DQT_PT : P_FF;
                end
                else if (marker_code_reg == jmsp_pkg::MK_DHT)
                begin
                    phase_next = P_DHT_TC;
                end
                else if (marker_code_reg == jmsp_pkg::MK_SOS)
                begin
                    phase_next = (len_m2 != 16'd0) ? P_SOS_SKIP : P_SOS_DATA;
                end
                else
                begin
                    phase_next = (len_m2 != 16'd0) ? P_SKIP : P_FF;
                end
            end
            P_SOF_PREC:
            begin
                phase_next = P_SOF_H_HI;
            end
            P_SOF_H_LO, P_SOF_W_LO:
            begin
                phase_next    = (phase_reg == P_SOF_H_LO) ? P_SOF_W_HI : P_SOF_NC;
                emit          = 1'b1;
                res.event_res = (phase_reg == P_SOF_H_LO) ? jmsp_pkg::EV_HEIGHT
                                                          : jmsp_pkg::EV_WIDTH;
                res.value     = word;
            end
            P_SOF_NC:
            begin
                comp_total_next = byte_reg;
                field_cnt_next  = 12'd0;
                phase_next      = (byte_reg != 8'd0) ? P_SOF_CID : P_FF;
                emit            = 1'b1;
                res.event_res   = jmsp_pkg::EV_COMP_COUNT;
                res.value       = {8'd0, byte_reg};
            end
            P_SOF_CID:
            begin
                comp_hold_next = {byte_reg, 8'd0};
                phase_next     = P_SOF_SAMP;
            end
            P_SOF_SAMP:
            begin
                comp_hold_next = {comp_hold_reg[15:8], byte_reg};
                phase_next     = P_SOF_TQ;
            end
            P_SOF_TQ:
            begin
                field_cnt_next = cnt_inc;
                phase_next     = (cnt_inc == {4'd0, comp_total_reg}) ? P_FF : P_SOF_CID;
                emit           = 1'b1;
                res.event_res  = jmsp_pkg::EV_COMP_INFO;
                res.table_id   = byte_reg[3:0];
                res.item_index = field_cnt_reg;
                res.value      = {8'd0, comp_hold_reg[15:8]};
                res.h_factor   = comp_hold_reg[7:4];
                res.v_factor   = comp_hold_reg[3:0];
            end
            P_DQT_PT:
            begin
                cur_table_next = byte_reg[3:0];
                wide_next      = (byte_reg[7:4] != 4'd0);
                field_cnt_next = 12'd0;
                phase_next     = P_DQT_E_HI;
            end
            P_DQT_E_HI, P_DQT_E_LO:
            begin
                if (phase_reg == P_DQT_E_HI && wide_reg)
                begin
                    held_hi_next = byte_reg;
                    phase_next   = P_DQT_E_LO;
                end
                else
                begin
                    emit           = 1'b1;
                    res.event_res  = jmsp_pkg::EV_QUANT;
                    res.table_id   = cur_table_reg;
                    res.item_index = field_cnt_reg;
                    res.value      = (phase_reg == P_DQT_E_LO) ? word : {8'd0, byte_reg};
                    field_cnt_next = cnt_inc;
                    phase_next     = P_DQT_E_HI;
                    if (cnt_inc == jmsp_pkg::DQT_ENTRIES)
                    begin
                        // clamp the remainder at zero on a short segment
                        if (seg_rem_reg > dqt_dec)
                        begin
                            seg_rem_next = seg_rem_reg - dqt_dec;
                            phase_next   = P_DQT_PT;
                        end
                        else
                        begin
                            seg_rem_next = 16'd0;
                            phase_next   = P_FF;
                        end
                    end
                end
            end
            P_DHT_TC:
            begin
                cur_table_next  = byte_reg[3:0];
                field_cnt_next  = 12'd0;
                sym_total_next  = 12'd0;
                phase_next      = P_DHT_CNT;
                emit            = 1'b1;
                res.event_res   = jmsp_pkg::EV_HUFF_HDR;
                res.table_id    = byte_reg[3:0];
                res.table_class = byte_reg[7:4];
            end
            P_DHT_CNT:
            begin
                emit           = 1'b1;
                res.event_res  = jmsp_pkg::EV_CODE_COUNT;
                res.item_index = field_cnt_reg;
                res.value      = {8'd0, byte_reg};
                sym_total_next = sym_total_reg + {4'd0, byte_reg};
                field_cnt_next = cnt_inc;
                if (cnt_inc >= jmsp_pkg::DHT_COUNTS)
                begin
                    field_cnt_next = 12'd0;
                    phase_next     = (sym_total_next != 12'd0) ? P_DHT_SYM : P_FF;
                end
            end
            P_DHT_SYM:
            begin
                emit           = 1'b1;
                res.event_res  = jmsp_pkg::EV_SYMBOL;
                res.item_index = field_cnt_reg;
                res.value      = {8'd0, byte_reg};
                field_cnt_next = cnt_inc;
                if (cnt_inc == sym_total_reg)
                begin
                    phase_next = P_FF;
                end
            end
            P_SOS_SKIP, P_SKIP:
            begin
                seg_rem_next = rem_dec;
                if (rem_dec == 16'd0)
                begin
                    phase_next = (phase_reg == P_SKIP) ? P_FF : P_SOS_DATA;
                end
            end
            P_SOS_DATA:
            begin
                if (byte_reg == jmsp_pkg::BYTE_FF)
                begin
                    phase_next = P_SOS_FF;
                end
                else
                begin
                    emit          = 1'b1;
                    res.event_res = jmsp_pkg::EV_DATA;
                    res.value     = {8'd0, byte_reg};
                end
            end
            P_SOS_FF:
            begin
                priority if (byte_reg == jmsp_pkg::BYTE_00)
                begin
                    phase_next    = P_SOS_DATA;
                    emit          = 1'b1;
                    res.event_res = jmsp_pkg::EV_DATA;
                    res.value     = {8'd0, jmsp_pkg::BYTE_FF};
                end
                else if (byte_reg == jmsp_pkg::MK_EOI)
                begin
                    phase_next     = P_DONE;
                    emit           = 1'b1;
                    res.event_res  = jmsp_pkg::EV_FINISHED;
                    res.stream_end = 1'b1;
                end
                else if (byte_reg >= jmsp_pkg::MK_RST_LO && byte_reg <= jmsp_pkg::MK_RST_HI)
                begin
                    // drop restart markers
                    phase_next = P_SOS_DATA;
                end
                else
                begin
                    phase_next     = P_DONE;
                    emit           = 1'b1;
                    res.event_res  = jmsp_pkg::EV_DATA;
                    res.value      = {8'd0, byte_reg};
                    res.stream_end = 1'b1;
                end
            end
            default:
            begin
                phase_next = P_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg     <= 1'b0;
            phase_reg       <= P_SOI1;
            marker_code_reg <= 8'd0;
            seg_rem_reg     <= 16'd0;
            field_cnt_reg   <= 12'd0;
            held_hi_reg     <= 8'd0;
            wide_reg        <= 1'b0;
            cur_table_reg   <= 4'd0;
            comp_total_reg  <= 8'd0;
            comp_hold_reg   <= 16'd0;
            sym_total_reg   <= 12'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                marker_code_reg <= marker_code_next;
                seg_rem_reg     <= seg_rem_next;
                field_cnt_reg   <= field_cnt_next;
                held_hi_reg     <= held_hi_next;
                wide_reg        <= wide_next;
                cur_table_reg   <= cur_table_next;
                comp_total_reg  <= comp_total_next;
                comp_hold_reg   <= comp_hold_next;
                sym_total_reg   <= sym_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= byte_value;
        end
    end

endmodule
